>>> rtl/core/icf_pkg.sv
// ----------------------------------------------------------------------------
// icf_pkg
// Shared types and constants for the Fenwick tree inversion counter.
// ----------------------------------------------------------------------------
package icf_pkg;

    localparam int MAX_VALUE = 1023;

    localparam int VALUE_W = 10;                      // value field
    localparam int COUNT_W = 32;                      // tree counts, item counter
    localparam int TOTAL_W = 63;                      // inversion total

    localparam int DEPTH   = MAX_VALUE + 1;           // tree entries 0..MAX_VALUE
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int POS_W   = IDX_W + 1;               // walk position, may step past MAX_VALUE
    localparam int EPOCH_W = 8;                       // sequence tag kept with each entry
    localparam int WORD_W  = EPOCH_W + COUNT_W;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_QUERY,
        ST_DIFF,
        ST_UPDATE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic take;        // capture request, apply restart
        logic clr_step;    // write one zero entry of the clearing pass
        logic q_init;      // start prefix walk at value-1
        logic q_run;       // prefix walk step
        logic diff;        // form item count minus prefix, start update walk
        logic u_run;       // update walk step
        logic finish;      // load result, commit counters
    } cmd_t;

    typedef struct packed {
        logic wrap;        // restart at last epoch: clearing pass needed
        logic clr_last;
        logic bad;
        logic q_done;
        logic u_done;
    } status_t;

endpackage

>>> rtl/core/icf_ifs.sv
// ----------------------------------------------------------------------------
// icf_in_if / icf_out_if
// Valid/ready channels for requests and results of the inversion counter.
// ----------------------------------------------------------------------------
interface icf_in_if
    import icf_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic               restart;

    modport source (output valid, output value, output restart, input ready);
    modport sink   (input valid, input value, input restart, output ready);
endinterface

interface icf_out_if
    import icf_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] earlier_not_smaller;
    logic [TOTAL_W-1:0] running_total;
    logic               bad_value;

    modport source (output valid, output earlier_not_smaller, output running_total,
                    output bad_value, input ready);
    modport sink   (input valid, input earlier_not_smaller, input running_total,
                    input bad_value, output ready);
endinterface

>>> rtl/core/icf_ram.sv
// ----------------------------------------------------------------------------
// icf_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module icf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/icf_datapath.sv
// ----------------------------------------------------------------------------
// icf_datapath
// Tree memory, walk address logic, counters and result registers.
// ----------------------------------------------------------------------------
module icf_datapath
    import icf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [VALUE_W-1:0] in_value,
    input  logic               in_restart,
    input  cmd_t               cmd,
    output status_t            sts,
    output logic [COUNT_W-1:0] res_earlier,
    output logic [TOTAL_W-1:0] res_total,
    output logic               res_bad
);

    logic [VALUE_W-1:0] val_reg;
    logic [POS_W-1:0]   pos_reg,   pos_next;
    logic               rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]   rd_addr_reg;
    logic [COUNT_W-1:0] acc_reg,   acc_next;
    logic [COUNT_W-1:0] ge_reg;
    logic [COUNT_W-1:0] items_reg, items_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [EPOCH_W-1:0] epoch_reg, epoch_next;
    logic [IDX_W-1:0]   clr_reg,   clr_next;
    logic [COUNT_W-1:0] earlier_reg;
    logic [TOTAL_W-1:0] res_total_reg;
    logic               res_bad_reg;

    logic [POS_W-1:0]   pos_low;
    logic               pos_ok;
    logic               bad;
    logic [WORD_W-1:0]  rd_data;
    logic [COUNT_W-1:0] rd_cnt;
    logic [TOTAL_W:0]   sum;
    logic [TOTAL_W-1:0] sat_total;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [WORD_W-1:0]  ram_wdata;

    assign pos_low = pos_reg & (~pos_reg + POS_W'(1));
    assign pos_ok  = (pos_reg != '0) && (32'(pos_reg) <= 32'(MAX_VALUE));
    assign bad     = (val_reg == '0) || (32'(val_reg) > 32'(MAX_VALUE));

    // entries tagged with an older epoch belong to a finished sequence
    assign rd_cnt = (rd_data[WORD_W-1 -: EPOCH_W] == epoch_reg) ? rd_data[COUNT_W-1:0] : '0;

    assign sum       = {1'b0, total_reg} + (TOTAL_W+1)'(ge_reg);
    assign sat_total = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];

    assign sts.wrap     = in_restart && (epoch_reg == '1);
    assign sts.clr_last = (32'(clr_reg) == 32'(DEPTH - 1));
    assign sts.bad      = bad;
    assign sts.q_done   = (pos_reg == '0) && !rd_vld_reg;
    assign sts.u_done   = !pos_ok && !rd_vld_reg;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = rd_addr_reg;
        ram_wdata = {epoch_reg, rd_cnt + COUNT_W'(1)};
        if (cmd.clr_step)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = {epoch_reg, {COUNT_W{1'b0}}};
        end
        else if (cmd.u_run && rd_vld_reg)
        begin
            ram_we = 1'b1;
        end
    end

    icf_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_tree (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (pos_reg[IDX_W-1:0]),
        .rdata (rd_data)
    );

    always_comb
    begin
        pos_next    = pos_reg;
        rd_vld_next = 1'b0;
        acc_next    = acc_reg;
        items_next  = items_reg;
        total_next  = total_reg;
        epoch_next  = epoch_reg;
        clr_next    = clr_reg;

        if (cmd.take && in_restart)
        begin
            items_next = '0;
            total_next = '0;
            epoch_next = epoch_reg + EPOCH_W'(1);
        end
        if (cmd.clr_step)
        begin
            clr_next = sts.clr_last ? '0 : clr_reg + IDX_W'(1);
        end
        if (cmd.q_init)
        begin
            pos_next = POS_W'(val_reg) - POS_W'(1);
            acc_next = '0;
        end
        if (cmd.q_run)
        begin
            if (pos_reg != '0)
            begin
                pos_next    = pos_reg - pos_low;
                rd_vld_next = 1'b1;
            end
            if (rd_vld_reg)
            begin
                acc_next = acc_reg + rd_cnt;
            end
        end
        if (cmd.diff)
        begin
            pos_next = POS_W'(val_reg);
        end
        if (cmd.u_run && pos_ok)
        begin
            pos_next    = pos_reg + pos_low;
            rd_vld_next = 1'b1;
        end
        if (cmd.finish && !bad)
        begin
            items_next = items_reg + COUNT_W'(1);
            total_next = sat_total;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            rd_vld_reg <= 1'b0;
            items_reg  <= '0;
            total_reg  <= '0;
            epoch_reg  <= '0;
            clr_reg    <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            rd_vld_reg <= rd_vld_next;
            items_reg  <= items_next;
            total_reg  <= total_next;
            epoch_reg  <= epoch_next;
            clr_reg    <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg     <= acc_next;
        rd_addr_reg <= pos_reg[IDX_W-1:0];
        if (cmd.take)
        begin
            val_reg <= in_value;
        end
        if (cmd.diff)
        begin
            ge_reg <= items_reg - acc_reg;
        end
        if (cmd.finish)
        begin
            earlier_reg   <= bad ? '0 : ge_reg;
            res_total_reg <= bad ? total_reg : sat_total;
            res_bad_reg   <= bad;
        end
    end

    assign res_earlier = earlier_reg;
    assign res_total   = res_total_reg;
    assign res_bad     = res_bad_reg;

endmodule

>>> rtl/core/icf_ctrl.sv
// ----------------------------------------------------------------------------
// icf_ctrl
// Sequencer: clearing pass, prefix walk, update walk and result handoff.
// ----------------------------------------------------------------------------
module icf_ctrl
    import icf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t sts,
    output cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   pend_reg,  pend_next;       // clearing pass belongs to a held request
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign slot_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = pend_reg ? ST_CHECK : ST_IDLE;
                    pend_next  = 1'b0;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    if (sts.wrap)
                    begin
                        state_next = ST_CLEAR;
                        pend_next  = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                if (sts.bad)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.q_init = 1'b1;
                    state_next = ST_QUERY;
                end
            end
            ST_QUERY:
            begin
                cmd.q_run = 1'b1;
                if (sts.q_done)
                begin
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.u_run = 1'b1;
                if (sts.u_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/inversion_counter_fenwick.sv
// ----------------------------------------------------------------------------
// inversion_counter_fenwick
// Streaming inversion counter over a binary indexed tree of value counts.
// ----------------------------------------------------------------------------
// One request at a time. A request with a value in 1..MAX_VALUE runs a prefix
// walk of popcount(value-1) reads; the tree read is registered, so the walk
// drains its last read before it ends. It then runs a read-modify-write
// update walk over the tree entries on the path from value up to MAX_VALUE.
// Sequencing adds four steps: accept, check, difference and finish. For
// MAX_VALUE = 1023 the two walks always visit 10 entries between them. The
// walks share the single tree RAM (one write and one registered read port).
// A bad value skips both walks. The result sits in an output register, so
// the finished result may wait on the sink while the next request starts;
// the next request then holds in its finish state until the register is free.
// Restart is free in most cases: each tree entry carries an 8-bit sequence
// tag and stale tags read as zero. After reset, and on every 256th restart
// when the tag wraps, a clearing pass writes all MAX_VALUE+1 entries, one per
// cycle; no request is taken during the pass after reset, and a restart that
// triggers it completes after the pass.
// ----------------------------------------------------------------------------
module inversion_counter_fenwick
    import icf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    icf_in_if.sink   item,
    icf_out_if.source result
);

    cmd_t    cmd;
    status_t sts;

    // sequencer: owns handshakes and walk ordering
    icf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // tree RAM, counters and result register
    icf_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_value    (item.value),
        .in_restart  (item.restart),
        .cmd         (cmd),
        .sts         (sts),
        .res_earlier (result.earlier_not_smaller),
        .res_total   (result.running_total),
        .res_bad     (result.bad_value)
    );

    // one request in flight: no back-to-back acceptance
    a_single_request: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |=> !item.ready)
        else $error("request accepted while previous one in flight");

    // a flagged result reports no earlier items
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.bad_value) |-> (result.earlier_not_smaller == '0))
        else $error("bad value result carries a count");

    // the total already includes this item's contribution
    a_total_covers: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.bad_value)
            |-> (result.running_total >= TOTAL_W'(result.earlier_not_smaller)))
        else $error("running total below item contribution");

endmodule
